// ===== hdl/sbs_pkg.sv =====
// Shared types, constants and register map of the beacon scheduler.
package sbs_pkg;

   // Default width of all time values
   localparam int TIME_BITS_DEF = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FAST_SPEED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_RATE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_SPEED  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_RATE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_TIME   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_ANGLE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_SLOPE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DELAY = 3'd7;

   // Register reset values
   localparam logic [7:0]  RST_FAST_SPEED  = 8'd60;
   localparam logic [15:0] RST_FAST_RATE   = 16'd180;
   localparam logic [7:0]  RST_SLOW_SPEED  = 8'd5;
   localparam logic [15:0] RST_SLOW_RATE   = 16'd1800;
   localparam logic [15:0] RST_TURN_TIME   = 16'd15;
   localparam logic [7:0]  RST_TURN_ANGLE  = 8'd30;
   localparam logic [15:0] RST_TURN_SLOPE  = 16'd255;
   localparam logic [15:0] RST_START_DELAY = 16'd60;

   // Scheduling constants
   localparam int RETRY_SECONDS    = 2;
   localparam int HALF_TURN_TENTHS = 1800;
   localparam int FULL_TURN_TENTHS = 3600;
   localparam int MIN_PEG_SPEED    = 256;   // 1.0 mph in 8.8

   // Shared multiplier: signed 18 x signed 17
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Iterative divider: 34-bit dividend, 17-bit divisor
   localparam int DIV_NUM_W = 34;
   localparam int DIV_DEN_W = 17;

   typedef struct packed {
      logic [31:0] now_seconds;
      logic        fix_ok;
      logic        speed_known;
      logic [15:0] speed_mph;
      logic        course_known;
      logic [11:0] course_tenths;
   } req_type;

   typedef struct packed {
      logic        send_now;
      logic        corner_pegged;
      logic [31:0] next_due;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  fast_speed;
      logic [15:0] fast_rate;
      logic [7:0]  slow_speed;
      logic [15:0] slow_rate;
      logic [15:0] turn_time;
      logic [7:0]  turn_angle;
      logic [15:0] turn_slope;
      logic [15:0] start_delay;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_RATE,
      ST_MUL_PEG,
      ST_DIV_WAIT,
      ST_FINISH
   } sbs_state_type;

   // Controls from the sequencer to the datapath
   typedef struct packed {
      logic req_ready;
      logic mul_rate;
      logic mul_peg;
      logic div_start;
      logic peg_eval;
      logic commit;
   } ctl_type;

endpackage

// ===== hdl/sbs_csr.sv =====
// Configuration register file of the beacon scheduler.
module sbs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sbs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output sbs_pkg::cfg_type              cfg
);
   import sbs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FAST_SPEED:  cfg_in.fast_speed  = csr_wdata[7:0];
            CSR_FAST_RATE:   cfg_in.fast_rate   = csr_wdata;
            CSR_SLOW_SPEED:  cfg_in.slow_speed  = csr_wdata[7:0];
            CSR_SLOW_RATE:   cfg_in.slow_rate   = csr_wdata;
            CSR_TURN_TIME:   cfg_in.turn_time   = csr_wdata;
            CSR_TURN_ANGLE:  cfg_in.turn_angle  = csr_wdata[7:0];
            CSR_TURN_SLOPE:  cfg_in.turn_slope  = csr_wdata;
            CSR_START_DELAY: cfg_in.start_delay = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_speed  <= RST_FAST_SPEED;
         cfg_ff.fast_rate   <= RST_FAST_RATE;
         cfg_ff.slow_speed  <= RST_SLOW_SPEED;
         cfg_ff.slow_rate   <= RST_SLOW_RATE;
         cfg_ff.turn_time   <= RST_TURN_TIME;
         cfg_ff.turn_angle  <= RST_TURN_ANGLE;
         cfg_ff.turn_slope  <= RST_TURN_SLOPE;
         cfg_ff.start_delay <= RST_START_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/sbs_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module sbs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sbs_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [sbs_pkg::DIV_DEN_W-1:0] divisor,
   output logic                          done,
   output logic [sbs_pkg::DIV_NUM_W-1:0] quotient
);
   import sbs_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_NUM_W - 1);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_DEN_W:0]   rem_shift;
   logic [DIV_DEN_W+1:0] trial;
   logic                 fits;

   // Shift in the next dividend bit and try to subtract the divisor
   always_comb begin
      rem_shift = {rem_ff, num_ff[DIV_NUM_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, den_ff};
      fits      = ~trial[DIV_DEN_W+1];
   end

   // Advance one step, or load a new operand pair
   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         rem_in = fits ? trial[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/sbs_ctrl.sv =====
// Sequencer that steps one tick through multiply, divide and update.
module sbs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             div_done,
   input  logic             out_free,
   output sbs_pkg::ctl_type ctl
);
   import sbs_pkg::*;

   sbs_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_MUL_RATE;
         ST_MUL_RATE: state_in = ST_MUL_PEG;
         ST_MUL_PEG:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_FINISH;
         ST_FINISH:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE:     ctl.req_ready = 1'b1;
         ST_MUL_RATE: ctl.mul_rate  = 1'b1;
         ST_MUL_PEG: begin
            ctl.mul_peg   = 1'b1;
            ctl.div_start = 1'b1;
         end
         ST_DIV_WAIT: ctl.peg_eval = 1'b1;
         ST_FINISH:   ctl.commit   = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/smart_beacon_scheduler_unit.sv =====
// Top level of the SmartBeaconing scheduler for one tracker beacon.
//
// Each request is a once-per-second tick with the time and a GPS sample; each
// request gives exactly one response: send_now, corner_pegged and next_due.
// Both channels use valid/ready. A request is taken only while the sequencer
// is idle, so the next request waits until the previous tick has finished. The
// 34-step restoring divider forms the proportional rate; a shared 18x17
// multiplier serves the rate numerator and the corner test.
// A finished response sits in an output register, so the next request is
// accepted while the receiver stalls; a tick that finishes while the output
// register is still full waits in its last step until the register frees.
// Configuration is written through csr_wr_en/csr_index/csr_wdata with no wait
// state; the user must write it only while the block is idle (not enforced).
// Reset (synchronous, active high) loads the register defaults, clears the
// last send time and due time, marks course zero as the last sent course and
// arms the start delay for the first tick. TIME_BITS sets the width of the
// internal time counters; times wrap at that width.
module smart_beacon_scheduler_unit #(
   parameter int TIME_BITS = sbs_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sbs_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sbs_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [sbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sbs_pkg::*;

   localparam int TW = TIME_BITS;

   cfg_type cfg;
   ctl_type ctl;

   // Captured tick
   logic [TW-1:0] now_ff, now_in;
   logic          fix_ff, fix_in;
   logic          spk_ff, spk_in;
   logic [15:0]   spd_ff, spd_in;
   logic          crk_ff, crk_in;
   logic [11:0]   crs_ff, crs_in;

   // Scheduler state
   logic [TW-1:0] last_time_ff, last_time_in;
   logic [11:0]   last_course_ff, last_course_in;
   logic          course_valid_ff, course_valid_in;
   logic [TW-1:0] due_ff, due_in;
   logic          started_ff, started_in;

   // Shared unit results
   logic signed [MUL_P_W-1:0] prod_ff, prod_in;
   logic                      peg_ff, peg_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                 out_free;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] quotient;
   logic [DIV_NUM_W-1:0] dividend;
   logic [DIV_DEN_W-1:0] divisor;

   logic [11:0]               diff;
   logic signed [13:0]        change;
   logic signed [13:0]        margin;
   logic [11:0]               angle10;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic [28:0]               slope_term;
   logic                      lhs_gt;
   logic                      time_ok;

   logic [16:0]   avg_sum;
   logic [31:0]   rate;
   logic [TW-1:0] rate_t;
   logic [TW-1:0] cand;
   logic [TW-1:0] due_mid;
   logic [TW-1:0] due_new;
   logic          pegged;
   logic          send;

   sbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .div_done  (div_done),
      .out_free  (out_free),
      .ctl       (ctl)
   );

   // Rate dividend 2*fast_rate*fast_speed*256 + speed over divisor 2*speed
   assign dividend = DIV_NUM_W'({prod_ff[23:0], 9'b0}) + DIV_NUM_W'(spd_ff);
   assign divisor  = {spd_ff, 1'b0};

   sbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = ctl.req_ready;

   // Heading change against the last sent course, less the base threshold
   always_comb begin
      diff    = (crs_ff > last_course_ff) ? (crs_ff - last_course_ff)
                                          : (last_course_ff - crs_ff);
      change  = (diff <= 12'(HALF_TURN_TENTHS))
                ? $signed({2'b00, diff})
                : $signed(14'(FULL_TURN_TENTHS)) - $signed({2'b00, diff});
      angle10 = {1'b0, cfg.turn_angle, 3'b000} + {3'b000, cfg.turn_angle, 1'b0};
      margin  = change - $signed({2'b00, angle10});
   end

   // Select operands of the shared multiplier
   always_comb begin
      if (ctl.mul_peg) begin
         mul_a = {{(MUL_A_W-14){margin[13]}}, margin};
         mul_b = {1'b0, spd_ff};
      end else begin
         mul_a = {2'b00, cfg.fast_rate};
         mul_b = {9'b0, cfg.fast_speed};
      end
      mul_p = mul_a * mul_b;
   end

   // Corner test: (change - 10*angle)*speed > 2560*slope, turn time passed
   always_comb begin
      slope_term = {2'b00, cfg.turn_slope, 11'b0} + {4'b0000, cfg.turn_slope, 9'b0};
      lhs_gt     = prod_ff > $signed({6'b0, slope_term});
      time_ok    = (now_ff >= last_time_ff) &&
                   ((now_ff - last_time_ff) >= TW'(cfg.turn_time));
   end

   // Straight-line rate in whole seconds
   always_comb begin
      avg_sum = {1'b0, cfg.fast_rate} + {1'b0, cfg.slow_rate} + 17'd1;
      priority if (!spk_ff) begin
         rate = 32'(avg_sum[16:1]);
      end else if (spd_ff > {cfg.fast_speed, 8'h00}) begin
         rate = 32'(cfg.fast_rate);
      end else if (spd_ff < {cfg.slow_speed, 8'h00} || spd_ff == 16'd0) begin
         rate = 32'(cfg.slow_rate);
      end else begin
         rate = quotient[31:0];
      end
      rate_t = TW'(rate);
   end

   // Pull the due time earlier, then send or retry once it has come
   always_comb begin
      cand    = peg_ff ? now_ff : last_time_ff + rate_t;
      due_mid = due_ff;
      pegged  = 1'b0;
      if (fix_ff && cand < due_ff) begin
         due_mid = cand;
         pegged  = peg_ff;
      end
      due_new         = due_mid;
      send            = 1'b0;
      last_time_in    = last_time_ff;
      last_course_in  = last_course_ff;
      course_valid_in = course_valid_ff;
      if (due_mid <= now_ff) begin
         if (!fix_ff) begin
            due_new = now_ff + TW'(RETRY_SECONDS);
         end else begin
            send            = 1'b1;
            last_time_in    = now_ff;
            last_course_in  = crs_ff;
            course_valid_in = crk_ff;
            due_new         = now_ff + rate_t;
         end
      end
      if (!ctl.commit) begin
         last_time_in    = last_time_ff;
         last_course_in  = last_course_ff;
         course_valid_in = course_valid_ff;
      end
   end

   // Capture the request and arm the start delay on the first tick
   always_comb begin
      now_in     = now_ff;
      fix_in     = fix_ff;
      spk_in     = spk_ff;
      spd_in     = spd_ff;
      crk_in     = crk_ff;
      crs_in     = crs_ff;
      due_in     = due_ff;
      started_in = started_ff;
      if (req_valid && ctl.req_ready) begin
         now_in = TW'(req_data.now_seconds);
         fix_in = req_data.fix_ok;
         spk_in = req_data.speed_known;
         spd_in = req_data.speed_mph;
         crk_in = req_data.course_known;
         crs_in = req_data.course_tenths;
         if (!started_ff) begin
            due_in     = TW'(req_data.now_seconds) + TW'(cfg.start_delay);
            started_in = 1'b1;
         end
      end else if (ctl.commit) begin
         due_in = due_new;
      end
   end

   // Hold multiplier and corner results between steps
   always_comb begin
      prod_in = prod_ff;
      peg_in  = peg_ff;
      if (ctl.mul_rate || ctl.mul_peg) begin
         prod_in = mul_p;
      end
      if (ctl.peg_eval) begin
         peg_in = spk_ff && (spd_ff >= 16'(MIN_PEG_SPEED)) && crk_ff &&
                  course_valid_ff && lhs_gt && time_ok;
      end
   end

   // Load the output register on commit, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ctl.commit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.send_now      = send;
         rsp_in.corner_pegged = pegged;
         rsp_in.next_due      = 32'(due_new);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff    <= '0;
         last_course_ff  <= '0;
         course_valid_ff <= 1'b1;
         due_ff          <= '0;
         started_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         last_time_ff    <= last_time_in;
         last_course_ff  <= last_course_in;
         course_valid_ff <= course_valid_in;
         due_ff          <= due_in;
         started_ff      <= started_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      now_ff  <= now_in;
      fix_ff  <= fix_in;
      spk_ff  <= spk_in;
      spd_ff  <= spd_in;
      crk_ff  <= crk_in;
      crs_ff  <= crs_in;
      prod_ff <= prod_in;
      peg_ff  <= peg_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
